/* sv/b64d_pkg.sv */
// ----------------------------------------------------------------------------
// b64d_pkg
// Types, character constants and the sextet lookup shared by the decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

	localparam logic [7:0] CHAR_LF  = 8'h0A;
	localparam logic [7:0] CHAR_CR  = 8'h0D;
	localparam logic [7:0] CHAR_PAD = 8'h3D;

	localparam int unsigned MAX_RESULTS = 4;

	typedef enum logic [1:0] {
		STATUS_OK         = 2'd0,
		STATUS_BAD_LENGTH = 2'd1,
		STATUS_NOT_WHOLE  = 2'd2
	} status_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_present;
		logic       final_result;
		logic [1:0] status;
	} result_t;

	typedef struct packed {
		result_t [MAX_RESULTS-1:0] entry;
		logic [2:0]                count;
	} bundle_t;

	function automatic logic [5:0] sextet_of(input logic [7:0] c);
		logic [7:0] v;
		v = 8'd0;
		if (c >= 8'h41 && c <= 8'h5A) begin
			v = c - 8'h41;
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			v = c - 8'h61 + 8'd26;
		end else if (c >= 8'h30 && c <= 8'h39) begin
			v = c - 8'h30 + 8'd52;
		end else if (c == 8'h2B) begin
			v = 8'd62;
		end else if (c == 8'h2F) begin
			v = 8'd63;
		end
		return v[5:0];
	endfunction

endpackage

/* sv/b64d_core.sv */
// ----------------------------------------------------------------------------
// b64d_core
// Group assembly state and per-character result bundle generation.
// ----------------------------------------------------------------------------
module b64d_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [7:0]        char_code,
	input  logic              stream_end,
	output b64d_pkg::bundle_t bundle
);

	logic [1:0]  gp_q;
	logic [17:0] acc_q;
	logic        twp_q;
	logic [23:0] hg_q;
	logic [1:0]  hpc_q;
	logic        hv_q;

	logic [1:0]  gp_n;
	logic [17:0] acc_n;
	logic        twp_n;
	logic [23:0] hg_n;
	logic [1:0]  hpc_n;
	logic        hv_n;

	logic        counted;
	logic        pad;
	logic [5:0]  v;
	logic        rel;
	logic [2:0]  good_count;
	logic [1:0]  good_status;
	logic [23:0] grp;
	b64d_pkg::result_t bare;

	assign counted = (char_code != b64d_pkg::CHAR_LF) && (char_code != b64d_pkg::CHAR_CR);
	assign pad     = (char_code == b64d_pkg::CHAR_PAD);
	assign v       = b64d_pkg::sextet_of(char_code);
	assign rel     = counted && hv_q;

	always_comb begin
		gp_n  = gp_q;
		acc_n = acc_q;
		twp_n = twp_q;
		hg_n  = hg_q;
		hpc_n = hpc_q;
		hv_n  = hv_q;
		if (counted) begin
			if (hv_q) begin
				hv_n = 1'b0;
			end
			if (gp_q != 2'd3) begin
				acc_n = {acc_q[11:0], v};
				if (gp_q == 2'd2) begin
					twp_n = pad;
				end
				gp_n = gp_q + 2'd1;
			end else begin
				hg_n  = {acc_q, v};
				hpc_n = {1'b0, pad} + {1'b0, twp_q};
				hv_n  = 1'b1;
				gp_n  = 2'd0;
				acc_n = 18'd0;
				twp_n = 1'b0;
			end
		end
	end

	always_comb begin
		bare.data_byte    = 8'd0;
		bare.byte_present = 1'b0;
		bare.final_result = 1'b1;
		bare.status       = b64d_pkg::STATUS_BAD_LENGTH;

		good_count  = 3'd3 - {1'b0, hpc_n};
		if (good_count == 3'd0) begin
			good_count = 3'd1;
		end
		good_status = (hpc_n != 2'd0) ? b64d_pkg::STATUS_NOT_WHOLE : b64d_pkg::STATUS_OK;
		grp = rel ? hg_q : hg_n;

		for (int i = 0; i < 3; i++) begin
			bundle.entry[i].data_byte    = grp[23-8*i -: 8];
			bundle.entry[i].byte_present = 1'b1;
			bundle.entry[i].final_result = 1'b0;
			bundle.entry[i].status       = b64d_pkg::STATUS_OK;
		end
		bundle.entry[3] = bare;
		bundle.count    = 3'd0;

		if (rel) begin
			bundle.count = stream_end ? 3'd4 : 3'd3;
		end else if (stream_end) begin
			if (gp_n != 2'd0 || !hv_n) begin
				bundle.entry[0] = bare;
				bundle.count    = 3'd1;
			end else begin
				bundle.count = good_count;
				for (int i = 0; i < 3; i++) begin
					if (good_count == 3'(i + 1)) begin
						bundle.entry[i].final_result = 1'b1;
						bundle.entry[i].status       = good_status;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gp_q  <= 2'd0;
			acc_q <= 18'd0;
			twp_q <= 1'b0;
			hg_q  <= 24'd0;
			hpc_q <= 2'd0;
			hv_q  <= 1'b0;
		end else if (accept) begin
			if (stream_end) begin
				gp_q  <= 2'd0;
				acc_q <= 18'd0;
				twp_q <= 1'b0;
				hg_q  <= 24'd0;
				hpc_q <= 2'd0;
				hv_q  <= 1'b0;
			end else begin
				gp_q  <= gp_n;
				acc_q <= acc_n;
				twp_q <= twp_n;
				hg_q  <= hg_n;
				hpc_q <= hpc_n;
				hv_q  <= hv_n;
			end
		end
	end

`ifndef SYNTHESIS
	a_held_only_on_boundary: assert property (@(posedge clk) disable iff (!arst_n)
		hv_q |-> gp_q != 2'd3)
		else $error("held group with full open group");
	a_pad_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		hpc_q != 2'd3)
		else $error("pad count out of range");
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && stream_end |=> gp_q == 2'd0 && !hv_q)
		else $error("state not cleared after stream end");
`endif

endmodule

/* sv/b64d_serializer.sv */
// ----------------------------------------------------------------------------
// b64d_serializer
// Result register that hands out a bundle one result per transfer.
// ----------------------------------------------------------------------------
module b64d_serializer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  b64d_pkg::bundle_t bundle,
	output logic              can_load,
	output logic              out_valid,
	input  logic              out_ready,
	output b64d_pkg::result_t result
);

	b64d_pkg::bundle_t bundle_s1;
	logic              valid_q;
	logic [1:0]        idx_q;
	logic              last;

	assign last      = (({1'b0, idx_q} + 3'd1) == bundle_s1.count);
	assign can_load  = !valid_q || (out_ready && last);
	assign out_valid = valid_q;
	assign result    = bundle_s1.entry[idx_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= 2'd0;
		end else if (valid_q && out_ready) begin
			if (last) begin
				valid_q <= 1'b0;
				idx_q   <= 2'd0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bundle_s1 <= bundle;
		end
	end

`ifndef SYNTHESIS
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> bundle_s1.count != 3'd0)
		else $error("empty bundle held");
	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> {1'b0, idx_q} < bundle_s1.count)
		else $error("result index past bundle");
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> can_load)
		else $error("bundle overwritten");
	a_final_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && result.final_result |-> last)
		else $error("final result before end of bundle");
`endif

endmodule

/* sv/base64_rgb_stream_decoder.sv */
// ----------------------------------------------------------------------------
// base64_rgb_stream_decoder
// Base64 character stream to byte stream decoder with end-of-stream status.
// ----------------------------------------------------------------------------
// One character can be taken every cycle. The results of a character (zero to
// four) are formed in the cycle it is taken and loaded into the output
// register, which sends one result per transfer from the next cycle on. A
// character that yields no result (most of them) is taken at once, even while
// earlier results are still being sent. A character that yields results
// (release of a held group, or the end of the stream) waits until the output
// register is empty or is sending its last result. With the output always
// ready a stream of four-character groups runs at one character per cycle;
// the input stalls only when a character with results arrives before the
// results of the previous such character are out, as with very short streams.
// Bytes leave before the final status; the consumer drops them when the
// status on the final result is not OK.
module base64_rgb_stream_decoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] char_code,
	input  logic       stream_end,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] data_byte,
	output logic       byte_present,
	output logic       final_result,
	output logic [1:0] status
);

	logic              accept;
	logic              can_load;
	b64d_pkg::bundle_t bundle;
	b64d_pkg::result_t result;

	assign in_ready = can_load || (bundle.count == 3'd0);
	assign accept   = in_valid && in_ready;

	b64d_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.char_code  (char_code),
		.stream_end (stream_end),
		.bundle     (bundle)
	);

	b64d_serializer u_serializer (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept && (bundle.count != 3'd0)),
		.bundle    (bundle),
		.can_load  (can_load),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.result    (result)
	);

	assign data_byte    = result.data_byte;
	assign byte_present = result.byte_present;
	assign final_result = result.final_result;
	assign status       = result.status;

endmodule

/* bench/tb_base64_rgb_stream_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_base64_rgb_stream_decoder
// Self-checking bench for the Base64 stream decoder. A driver feeds character
// transfers from a queue filled with directed streams (padding, skipped CR/LF,
// held group release, bad length, empty stream) and then random well-formed
// and broken streams. Each accepted character is run through a local decoder
// model; the monitor compares each result transfer with the oldest prediction.
// Both sides idle at random in the first two of three phases of the run.
// ----------------------------------------------------------------------------
module tb_base64_rgb_stream_decoder;

	localparam int STALL_LIMIT = 2000;
	localparam int TAIL_CYCLES = 16;
	localparam int TARGET_ITEMS = 280;

	typedef struct {
		logic [7:0] code;
		logic       last;
		logic       drain_first;
	} char_item_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] char_code = 8'd0;
	logic       stream_end = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] data_byte;
	logic       byte_present;
	logic       final_result;
	logic [1:0] status;

	char_item_t          char_q[$];
	b64d_pkg::result_t   decoded_q[$];
	int                  err_count = 0;
	int                  in_count = 0;
	int                  total_items = 1;
	int                  stall_cycles = 0;

	// decoder model state
	logic [1:0]  grp_pos = 2'd0;
	logic [17:0] acc = 18'd0;
	logic        third_pad = 1'b0;
	logic [23:0] held = 24'd0;
	logic [1:0]  held_pads = 2'd0;
	logic        held_ok = 1'b0;

	base64_rgb_stream_decoder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.char_code    (char_code),
		.stream_end   (stream_end),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.data_byte    (data_byte),
		.byte_present (byte_present),
		.final_result (final_result),
		.status       (status)
	);

	always #5 clk = ~clk;

	task automatic report(input string what, input int got, input int want);
		$display("mismatch %s: got %0h want %0h", what, got, want);
		err_count++;
	endtask

	function automatic logic [5:0] sextet_value(input logic [7:0] c);
		logic [7:0] d;
		d = 8'd0;
		if (c inside {[8'h41:8'h5A]}) begin
			d = c - 8'h41;
		end else if (c inside {[8'h61:8'h7A]}) begin
			d = c - 8'h47;
		end else if (c inside {[8'h30:8'h39]}) begin
			d = c + 8'h04;
		end else if (c == 8'h2B) begin
			d = 8'd62;
		end else if (c == 8'h2F) begin
			d = 8'd63;
		end
		return d[5:0];
	endfunction

	function automatic logic [7:0] b64_char(input int unsigned idx);
		if (idx < 26) begin
			return 8'(8'h41 + idx);
		end else if (idx < 52) begin
			return 8'(8'h61 + idx - 26);
		end else if (idx < 62) begin
			return 8'(8'h30 + idx - 52);
		end else if (idx == 62) begin
			return 8'h2B;
		end
		return 8'h2F;
	endfunction

	task automatic push_byte(input logic [7:0] b, input logic present, input logic fin,
			input b64d_pkg::status_t st);
		b64d_pkg::result_t r;
		r.data_byte = b;
		r.byte_present = present;
		r.final_result = fin;
		r.status = st;
		decoded_q.push_back(r);
	endtask

	task automatic decode_char(input logic [7:0] c, input logic last);
		logic [5:0]         v;
		logic               is_pad;
		int                 nbytes;
		b64d_pkg::status_t  st;
		if (c != b64d_pkg::CHAR_LF && c != b64d_pkg::CHAR_CR) begin
			v = sextet_value(c);
			is_pad = (c == b64d_pkg::CHAR_PAD);
			if (held_ok) begin
				push_byte(held[23:16], 1'b1, 1'b0, b64d_pkg::STATUS_OK);
				push_byte(held[15:8], 1'b1, 1'b0, b64d_pkg::STATUS_OK);
				push_byte(held[7:0], 1'b1, 1'b0, b64d_pkg::STATUS_OK);
				held_ok = 1'b0;
			end
			if (grp_pos < 2'd3) begin
				acc = {acc[11:0], v};
				if (grp_pos == 2'd2) begin
					third_pad = is_pad;
				end
				grp_pos = grp_pos + 2'd1;
			end else begin
				held = {acc, v};
				held_pads = {1'b0, is_pad} + {1'b0, third_pad};
				held_ok = 1'b1;
				grp_pos = 2'd0;
				acc = 18'd0;
				third_pad = 1'b0;
			end
		end
		if (last) begin
			if (grp_pos != 2'd0 || !held_ok) begin
				push_byte(8'd0, 1'b0, 1'b1, b64d_pkg::STATUS_BAD_LENGTH);
			end else begin
				nbytes = 3 - held_pads;
				st = (held_pads != 2'd0) ? b64d_pkg::STATUS_NOT_WHOLE : b64d_pkg::STATUS_OK;
				for (int i = 0; i < nbytes; i++) begin
					push_byte(held[23-8*i -: 8], 1'b1, i == nbytes - 1,
						(i == nbytes - 1) ? st : b64d_pkg::STATUS_OK);
				end
			end
			grp_pos = 2'd0;
			acc = 18'd0;
			third_pad = 1'b0;
			held = 24'd0;
			held_pads = 2'd0;
			held_ok = 1'b0;
		end
	endtask

	function automatic int send_idle_pct();
		int phase;
		phase = (in_count * 3) / total_items;
		return (phase == 0) ? 21 : (phase == 1) ? 74 : 0;
	endfunction

	function automatic int recv_idle_pct();
		int phase;
		phase = (in_count * 3) / total_items;
		return (phase == 0) ? 74 : (phase == 1) ? 21 : 0;
	endfunction

	// driver
	always @(posedge clk) begin : drive_proc
		logic       busy;
		char_item_t item;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			busy = in_valid;
			if (in_valid && in_ready) begin
				decode_char(char_code, stream_end);
				in_count++;
				busy = 1'b0;
			end
			if (!busy) begin
				if (char_q.size() > 0 && (!char_q[0].drain_first || decoded_q.size() == 0)
						&& $urandom_range(99) >= send_idle_pct()) begin
					item = char_q.pop_front();
					in_valid <= 1'b1;
					char_code <= item.code;
					stream_end <= item.last;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin : monitor_proc
		b64d_pkg::result_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (decoded_q.size() == 0) begin
					report("unexpected result, data_byte", data_byte, 0);
				end else begin
					want = decoded_q.pop_front();
					if (data_byte !== want.data_byte)
						report("data_byte", data_byte, want.data_byte);
					if (byte_present !== want.byte_present)
						report("byte_present", byte_present, want.byte_present);
					if (final_result !== want.final_result)
						report("final_result", final_result, want.final_result);
					if (status !== want.status)
						report("status", status, want.status);
				end
			end
			out_ready <= ($urandom_range(99) >= recv_idle_pct());
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	task automatic add_char(input logic [7:0] c, input logic last, input logic drain);
		char_item_t it;
		it.code = c;
		it.last = last;
		it.drain_first = drain;
		char_q.push_back(it);
	endtask

	task automatic add_text(input string s, input logic end_on_last);
		for (int i = 0; i < s.len(); i++) begin
			add_char(s[i], end_on_last && (i == s.len() - 1), 1'b0);
		end
	endtask

	initial begin
		char_item_t  strm[$];
		char_item_t  it;
		int          n_groups;
		int          n_pads;
		int          n_chars;
		int          stream_num;
		int unsigned pick;

		// directed streams
		add_text("TWFu", 1'b1);
		add_char(b64d_pkg::CHAR_LF, 1'b1, 1'b0);
		add_text("QQ==", 1'b1);
		add_text("QUI=", 1'b1);
		add_char(8'h00, 1'b0, 1'b0);
		add_char(8'hFF, 1'b0, 1'b0);
		add_char(b64d_pkg::CHAR_PAD, 1'b0, 1'b0);
		add_text("Z", 1'b0);
		add_char(b64d_pkg::CHAR_CR, 1'b0, 1'b0);
		add_text("az/+", 1'b0);
		add_char(b64d_pkg::CHAR_LF, 1'b1, 1'b0);
		add_text("QUJ", 1'b1);

		// random streams, mostly well formed
		stream_num = 0;
		while (char_q.size() < TARGET_ITEMS) begin
			strm.delete();
			if ($urandom_range(99) < 75) begin
				n_groups = ($urandom_range(9) == 0) ? $urandom_range(3, 4) : $urandom_range(1, 2);
				n_pads = $urandom_range(2);
				for (int g = 0; g < n_groups; g++) begin
					for (int k = 0; k < 4; k++) begin
						if ($urandom_range(9) == 0) begin
							it.code = $urandom_range(1) ? b64d_pkg::CHAR_CR : b64d_pkg::CHAR_LF;
							it.last = 1'b0;
							it.drain_first = 1'b0;
							strm.push_back(it);
						end
						it.code = b64_char($urandom_range(63));
						if (g == n_groups - 1 && k >= 4 - n_pads)
							it.code = b64d_pkg::CHAR_PAD;
						it.last = 1'b0;
						it.drain_first = 1'b0;
						strm.push_back(it);
					end
				end
				if ($urandom_range(3) == 0) begin
					it.code = $urandom_range(1) ? b64d_pkg::CHAR_CR : b64d_pkg::CHAR_LF;
					it.last = 1'b0;
					it.drain_first = 1'b0;
					strm.push_back(it);
				end
			end else begin
				n_chars = $urandom_range(1, 9);
				for (int k = 0; k < n_chars; k++) begin
					pick = $urandom_range(3);
					if (pick < 2) begin
						it.code = b64_char($urandom_range(63));
					end else if (pick == 2) begin
						it.code = 8'($urandom_range(255));
					end else begin
						case ($urandom_range(2))
							0: it.code = b64d_pkg::CHAR_CR;
							1: it.code = b64d_pkg::CHAR_LF;
							default: it.code = b64d_pkg::CHAR_PAD;
						endcase
					end
					it.last = 1'b0;
					it.drain_first = 1'b0;
					strm.push_back(it);
				end
			end
			strm[strm.size() - 1].last = 1'b1;
			strm[0].drain_first = (stream_num % 17 == 0);
			foreach (strm[i]) char_q.push_back(strm[i]);
			stream_num++;
		end
		total_items = char_q.size();

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (!(char_q.size() == 0 && !in_valid && decoded_q.size() == 0)
				&& stall_cycles < STALL_LIMIT) begin
			@(negedge clk);
		end
		if (stall_cycles >= STALL_LIMIT) begin
			$display("tb_base64_rgb_stream_decoder: errors");
		end else begin
			repeat (TAIL_CYCLES) @(negedge clk);
			if (decoded_q.size() != 0)
				report("results never arrived", 0, decoded_q.size());
			if (err_count == 0) begin
				$display("tb_base64_rgb_stream_decoder: clean");
			end else begin
				$display("tb_base64_rgb_stream_decoder: errors");
			end
		end
		$finish;
	end

endmodule
